@@ rtl/swsl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swsl_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SLOPE_W    = 25;
  localparam int FILL_W     = 3;
  localparam int FRAC_BITS  = 8;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W  = OUT_TDATA_W - SLOPE_W - FILL_W;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

@@ rtl/swsl_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swsl_div #(
  parameter int DVD_W = 33,
  parameter int DIV_W = 12
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire  [DVD_W-1:0]         dividend_i,
  input  wire  [DIV_W-1:0]         divisor_i,
  output swsl_pkg::div_stat_t      stat_o,
  output logic [DVD_W-1:0]         quotient_o
);
  import swsl_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] rem_d;
  logic [DVD_W-1:0] dvd_q;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             take;

  // restoring step: one quotient bit per cycle, shifted into the dividend register
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, div_q};
    take  = ~diff[DIV_W];
    rem_d = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DVD_W-2:0], take};
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = dvd_q;

endmodule

`default_nettype wire

@@ rtl/sliding_window_slope.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Least-squares slope over the newest WINDOW samples. Each accepted 16-bit sample
// enters a ring (the oldest one drops out once WINDOW are held), then the block
// returns the slope (n*Sxy - Sx*Sy)*256/(n*Sx2 - Sx^2) with x = 1 for the oldest
// sample, truncated toward zero, 8 fraction bits. With fewer than two samples the
// slope is 0 and slope_valid is low. One item at a time: IDLE takes the sample, the
// ring memory is walked with one RD and one ACC step per held sample, MUL, SUB and
// SGN form the products, the differences and the sign, the restoring divider makes
// one quotient bit per cycle over 16 + 3*clog2(WINDOW+1) + 8 dividend bits and then
// reports done, and FIN loads the output register. With fewer than two samples the
// walk and the divide are skipped. A finished result waits in the output register
// while the next sample is taken; a result that finds the output register still
// full stalls in FIN until it drains.
module sliding_window_slope #(
  parameter int WINDOW = 5
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire  [swsl_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,   // [15:0] sample
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  output logic [swsl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,   // [24:0] slope, [27:25] fill_count
  output logic [0:0]                          m_axis_tuser_o    // [0] slope_valid
);
  import swsl_pkg::*;

  localparam int NW    = $clog2(WINDOW + 1);
  localparam int PW    = $clog2(WINDOW);
  localparam int SYW   = SAMPLE_W + NW;
  localparam int SXW   = 2 * NW;
  localparam int SX2W  = 3 * NW;
  localparam int SXYW  = SAMPLE_W + 2 * NW;
  localparam int PRW   = SAMPLE_W + 3 * NW;
  localparam int NUMW  = PRW + 1;
  localparam int DPW   = 4 * NW;
  localparam int DENW  = DPW + 1;
  localparam int DVDW  = PRW + FRAC_BITS;

  typedef enum logic [2:0] {
    IDLE, RD, ACC, MUL, SUB, SGN, DIV, FIN
  } state_e;

  state_e              state_q;
  logic [PW-1:0]       oldest_q;
  logic [PW-1:0]       newest_q;
  logic [PW-1:0]       slot_q;
  logic [NW-1:0]       count_q;
  logic [NW-1:0]       k_q;
  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_q;
  logic [SYW-1:0]      sy_q;
  logic [SXW-1:0]      sx_q;
  logic [SX2W-1:0]     sx2_q;
  logic [SXYW-1:0]     sxy_q;
  logic [PRW-1:0]      p1_q;
  logic [PRW-1:0]      p2_q;
  logic [DPW-1:0]      p3_q;
  logic [DPW-1:0]      p4_q;
  logic [NUMW-1:0]     num_q;
  logic [DENW-1:0]     den_q;
  logic                neg_q;
  logic                ok_q;
  logic                ovalid_q;
  logic [SLOPE_W-1:0]  slope_q;
  logic [FILL_W-1:0]   fill_q;
  logic                sval_q;

  logic                in_fire;
  logic [PW-1:0]       newest_d;
  logic [PW-1:0]       oldest_d;
  logic [NW-1:0]       count_d;
  logic                full;
  logic                den_pos;
  logic [NUMW-1:0]     num_abs;
  logic [DVDW-1:0]     dividend;
  logic                div_start;
  div_stat_t           div_stat;
  logic [DVDW-1:0]     quot;
  logic [DVDW-1:0]     quot_signed;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

  assign s_axis_tready_o = (state_q == IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign full            = (count_q == NW'(WINDOW));
  assign newest_d        = ptr_inc(newest_q);
  assign oldest_d        = full ? ptr_inc(oldest_q) : oldest_q;
  assign count_d         = full ? count_q : count_q + 1'b1;

  assign den_pos   = ~den_q[DENW-1] & (den_q != '0);
  assign num_abs   = neg_q ? -num_q : num_q;
  assign dividend  = {num_abs[PRW-1:0], {FRAC_BITS{1'b0}}};
  assign div_start = (state_q == SGN) & den_pos;
  assign quot_signed = neg_q ? -quot : quot;

  swsl_div #(
    .DVD_W(DVDW),
    .DIV_W(DPW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (den_q[DPW-1:0]),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem[newest_d] <= s_axis_tdata_i[SAMPLE_W-1:0];
    end
    if (state_q == RD) begin
      rd_q <= mem[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= IDLE;
      oldest_q <= '0;
      newest_q <= PW'(WINDOW - 1);
      slot_q   <= '0;
      count_q  <= '0;
      k_q      <= '0;
      sy_q     <= '0;
      sx_q     <= '0;
      sx2_q    <= '0;
      sxy_q    <= '0;
      p1_q     <= '0;
      p2_q     <= '0;
      p3_q     <= '0;
      p4_q     <= '0;
      num_q    <= '0;
      den_q    <= '0;
      neg_q    <= 1'b0;
      ok_q     <= 1'b0;
      ovalid_q <= 1'b0;
      slope_q  <= '0;
      fill_q   <= '0;
      sval_q   <= 1'b0;
    end else begin
      if (ovalid_q && m_axis_tready_i && (state_q != FIN)) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_fire) begin
            oldest_q <= oldest_d;
            newest_q <= newest_d;
            count_q  <= count_d;
            slot_q   <= oldest_d;
            k_q      <= NW'(1);
            sy_q     <= '0;
            sx_q     <= '0;
            sx2_q    <= '0;
            sxy_q    <= '0;
            ok_q     <= 1'b0;
            state_q  <= (count_d < NW'(2)) ? FIN : RD;
          end
        end
        RD: begin
          state_q <= ACC;
        end
        ACC: begin
          sy_q  <= sy_q + SYW'(rd_q);
          sx_q  <= sx_q + SXW'(k_q);
          sx2_q <= sx2_q + SX2W'(SX2W'(k_q) * SX2W'(k_q));
          sxy_q <= sxy_q + SXYW'(k_q) * SXYW'(rd_q);
          if (k_q == count_q) begin
            state_q <= MUL;
          end else begin
            k_q     <= k_q + 1'b1;
            slot_q  <= ptr_inc(slot_q);
            state_q <= RD;
          end
        end
        MUL: begin
          p1_q    <= PRW'(count_q) * PRW'(sxy_q);
          p2_q    <= PRW'(sx_q) * PRW'(sy_q);
          p3_q    <= DPW'(count_q) * DPW'(sx2_q);
          p4_q    <= DPW'(sx_q) * DPW'(sx_q);
          state_q <= SUB;
        end
        SUB: begin
          num_q   <= {1'b0, p1_q} - {1'b0, p2_q};
          den_q   <= {1'b0, p3_q} - {1'b0, p4_q};
          neg_q   <= (p1_q < p2_q);
          state_q <= SGN;
        end
        SGN: begin
          ok_q    <= den_pos;
          state_q <= den_pos ? DIV : FIN;
        end
        DIV: begin
          if (div_stat.done) begin
            state_q <= FIN;
          end
        end
        FIN: begin
          if (!ovalid_q || m_axis_tready_i) begin
            ovalid_q <= 1'b1;
            slope_q  <= ok_q ? quot_signed[SLOPE_W-1:0] : '0;
            fill_q   <= FILL_W'(count_q);
            sval_q   <= ok_q;
            state_q  <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, fill_q, slope_q};
  assign m_axis_tuser_o  = sval_q;

endmodule

`default_nettype wire

@@ verif/sliding_window_slope_tb.sv @@
`timescale 1ns / 1ps

module sliding_window_slope_tb;
  import swsl_pkg::*;

  localparam int WIN        = 5;
  localparam int WDOG_LIMIT = 4000;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic               ok;
    logic [FILL_W-1:0]  fill;
  } slope_res_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;

  sliding_window_slope #(.WINDOW(WIN)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // window predictor state
  logic [SAMPLE_W-1:0] win_mem [WIN];
  int win_old = 0;
  int win_new = WIN - 1;
  int win_cnt = 0;

  slope_res_t slope_q[$];
  int src_pct = 0;
  int snk_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int bad = 0;
  int idle_cyc = 0;
  int walk_lvl = 32768;
  int ramp_step = 0;

  function automatic slope_res_t step_window(input logic [SAMPLE_W-1:0] smp);
    slope_res_t r;
    longint n, sx, sy, sxy, sx2, num, den, mag, q, y;
    int slot;
    if (win_cnt == WIN) begin
      win_old = (win_old + 1) % WIN;
      win_cnt = WIN - 1;
    end
    win_new = (win_new + 1) % WIN;
    win_mem[win_new] = smp;
    win_cnt++;
    n = win_cnt;
    sx = 0; sy = 0; sxy = 0; sx2 = 0;
    slot = win_old;
    for (int k = 1; k <= n; k++) begin
      y = longint'(win_mem[slot]);
      sx += k;
      sy += y;
      sxy += k * y;
      sx2 += k * k;
      slot = (slot + 1) % WIN;
    end
    num = n * sxy - sx * sy;
    den = n * sx2 - sx * sx;
    r.fill = FILL_W'(win_cnt);
    if (n < 2 || den <= 0) begin
      r.slope = '0;
      r.ok = 1'b0;
    end else begin
      mag = (num < 0) ? -num : num;
      q = (mag << FRAC_BITS) / den;
      r.slope = SLOPE_W'((num < 0) ? -q : q);
      r.ok = 1'b1;
    end
    return r;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < src_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= IN_TDATA_W'($urandom);
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    do @(posedge clk_i); while (!s_tready);
    slope_q.push_back(step_window(smp));
  endtask

  // mix of uniform noise, rail values, slow walks and ramps
  function automatic logic [SAMPLE_W-1:0] gen_sample();
    case ($urandom_range(3))
      0: return SAMPLE_W'($urandom);
      1: begin
        if ($urandom_range(1)) return SAMPLE_W'(65535 - $urandom_range(3));
        return SAMPLE_W'($urandom_range(3));
      end
      2: walk_lvl += int'($urandom_range(512)) - 256;
      default: begin
        if ($urandom_range(7) == 0) ramp_step = int'($urandom_range(16384)) - 8192;
        walk_lvl += ramp_step;
      end
    endcase
    if (walk_lvl < 0) walk_lvl = 0;
    if (walk_lvl > 65535) walk_lvl = 65535;
    return SAMPLE_W'(walk_lvl);
  endfunction

  task automatic run_directed();
    logic [SAMPLE_W-1:0] pat [$];
    src_pct = 0;
    snk_pct = 0;
    // lone sample, rise, fall and alternation to fill the window, then flats and ramps
    pat = {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000,
           16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
           16'h0000, 16'h3FFF, 16'h7FFF, 16'hBFFF, 16'hFFFF,
           16'hFFFF, 16'hBFFF, 16'h7FFF, 16'h5555, 16'hAAAA};
    foreach (pat[i]) send_sample(pat[i]);
  endtask

  task automatic run_random(input int cnt, input int src, input int snk);
    src_pct = src;
    snk_pct = snk;
    repeat (cnt) send_sample(gen_sample());
  endtask

  // long sink hold-off with the source streaming so the input backs up
  task automatic run_backpressure();
    src_pct = 0;
    snk_pct = 0;
    hold_req = HOLD_LEN;
    repeat (30) send_sample(gen_sample());
  endtask

  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_pct);
    end
  end

  always @(posedge clk_i) begin
    slope_res_t want;
    slope_res_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got.slope = m_tdata[SLOPE_W-1:0];
      got.fill = m_tdata[SLOPE_W +: FILL_W];
      got.ok = m_tuser[0];
      if (slope_q.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("%0t: unexpected transaction slope=%0d valid=%0b fill=%0d", $realtime,
                   $signed(got.slope), got.ok, got.fill);
      end else begin
        want = slope_q.pop_front();
        if (got !== want) begin
          bad++;
          if (bad <= 10)
            $display("%0t: mismatch slope exp=%0d act=%0d valid exp=%0b act=%0b fill exp=%0d act=%0d",
                     $realtime, $signed(want.slope), $signed(got.slope), want.ok, got.ok,
                     want.fill, got.fill);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(200, 0, 0);
    run_random(200, 59, 0);
    run_backpressure();
    run_random(200, 0, 59);
    run_random(200, 26, 26);
    s_tvalid <= 1'b0;
    snk_pct = 26;
    wait (slope_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (bad == 0 && slope_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
